/* design/l2sh_pkg.sv */
package l2sh_pkg;

	localparam int NUM_BUCKETS = 64;
	localparam int BKT_W       = $clog2(NUM_BUCKETS);
	// Wide enough for the encoder's unclamped values 0..64
	localparam int ENC_W       = 7;
	localparam logic [ENC_W-1:0] LAST_BKT = ENC_W'(NUM_BUCKETS - 1);
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	localparam logic ACTION_ADD  = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	typedef struct packed {
		logic        action;
		logic [63:0] value;
		logic [5:0]  bucket_select;
	} hist_in_t;

	typedef struct packed {
		logic [5:0]  bucket_index;
		logic [31:0] bucket_count;
		logic [31:0] sample_count;
		logic [63:0] value_sum;
		logic [63:0] min_value;
		logic [63:0] max_value;
	} hist_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} dp_cmd_t;

endpackage

/* design/log2_size_histogram_core.sv */
// A result word is registered after its item word has passed the capture,
// bucket RAM read and read-modify-write steps of the sequencer; a pending result
// can stall the write-back, and no new item word is accepted until it is done.
// Reset (arst_n low) clears all statistics and the per-bucket valid bits at
// once, so every bucket reads zero right after reset with no clearing pass.
module log2_size_histogram_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  l2sh_pkg::hist_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output l2sh_pkg::hist_out_t result
);
	import l2sh_pkg::*;

	dp_cmd_t cmd;

	// Sequencer: accept a word, look up its bucket, then write back and
	// load the output register once that register is free. The next item
	// word is accepted while a finished result still waits downstream.
	l2sh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd)
	);

	// Datapath: log2 bucket encoder, bucket count RAM with valid bits,
	// saturating counters, wrapping sum, min and max, output register.
	l2sh_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.result(result)
	);
endmodule

/* design/l2sh_ram.sv */
module l2sh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* design/l2sh_ctrl.sv */
module l2sh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output l2sh_pkg::dp_cmd_t cmd
);
	import l2sh_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold until the output register is free
				if (!out_valid_q || result_ready) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = cmd.update ? 1'b1 : (out_valid_q && !result_ready);
	end

	assign result_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || result_ready))
		else $error("result overwritten before taken");
	a_capture_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.lookup)
		else $error("lookup did not follow capture");
	a_rise_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.update))
		else $error("result valid without update");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.lookup, cmd.update}))
		else $error("overlapping datapath commands");
endmodule

/* design/l2sh_datapath.sv */
module l2sh_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  l2sh_pkg::hist_in_t  item,
	input  l2sh_pkg::dp_cmd_t   cmd,
	output l2sh_pkg::hist_out_t result
);
	import l2sh_pkg::*;

	logic        act_q;
	logic [63:0] value_q;
	logic [5:0]  sel_q;

	logic [BKT_W-1:0] idx_q;
	logic             in_range_q;

	logic [NUM_BUCKETS-1:0] valid_q;
	logic [31:0] total_q;
	logic [63:0] sum_q, min_q, max_q;
	hist_out_t   result_q;

	logic [BKT_W-1:0] enc_idx, rd_addr;
	logic [31:0]      ram_rdata, cur_cnt, inc_cnt;
	logic [31:0]      total_d;
	logic [63:0]      sum_d, min_d, max_d;
	logic             do_add;
	hist_out_t        result_d;

	// 0 for zero, else position of top set bit plus one, clamped to last bucket
	function automatic logic [ENC_W-1:0] bucket_of(logic [63:0] v);
		logic [ENC_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				idx = ENC_W'(i + 1);
			end
		end
		if (idx > LAST_BKT) begin
			idx = LAST_BKT;
		end
		return idx;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= item.action;
			value_q <= item.value;
			sel_q   <= item.bucket_select;
		end
		if (cmd.lookup) begin
			idx_q      <= rd_addr;
			in_range_q <= (int'(sel_q) < NUM_BUCKETS);
		end
		if (cmd.update) begin
			result_q <= result_d;
		end
	end

	assign enc_idx = BKT_W'(bucket_of(value_q));
	assign rd_addr = (act_q == ACTION_READ) ? BKT_W'(sel_q) : enc_idx;

	l2sh_ram #(
		.WIDTH(32),
		.DEPTH(NUM_BUCKETS)
	) u_bucket_ram (
		.clk  (clk),
		.we   (do_add),
		.waddr(idx_q),
		.wdata(inc_cnt),
		.re   (cmd.lookup),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		do_add  = cmd.update && (act_q == ACTION_ADD);
		// a bucket never written reads as zero
		cur_cnt = valid_q[idx_q] ? ram_rdata : 32'd0;
		inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 32'd1;
		total_d = (total_q == CNT_MAX) ? total_q : total_q + 32'd1;
		sum_d   = sum_q + value_q;
		min_d   = (value_q < min_q) ? value_q : min_q;
		max_d   = (value_q > max_q) ? value_q : max_q;

		if (act_q == ACTION_ADD) begin
			result_d.bucket_index = 6'(idx_q);
			result_d.bucket_count = inc_cnt;
			result_d.sample_count = total_d;
			result_d.value_sum    = sum_d;
			result_d.min_value    = min_d;
			result_d.max_value    = max_d;
		end else begin
			result_d.bucket_index = sel_q;
			result_d.bucket_count = in_range_q ? cur_cnt : 32'd0;
			result_d.sample_count = total_q;
			result_d.value_sum    = sum_q;
			result_d.min_value    = min_q;
			result_d.max_value    = max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (do_add) begin
			valid_q[idx_q] <= 1'b1;
			total_q        <= total_d;
			sum_q          <= sum_d;
			min_q          <= min_d;
			max_q          <= max_d;
		end
	end

	assign result = result_q;
endmodule
